/* sv/bpc_pkg.sv */
// Shared types and constants of the barometric compensation pipeline.
package bpc_pkg;

  localparam int unsigned FRONT_STAGES = 11;
  localparam int unsigned QUOT_BITS    = 40;
  localparam int unsigned BACK_STAGES  = 5;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP     = 2'd0,
    CFG_PRESS_LO = 2'd1,
    CFG_PRESS_HI = 2'd2,
    CFG_PRESS_P9 = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] temp_centi;
    logic        [31:0] pressure_q24_8;
    logic               pressure_ok;
  } out_item_t;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coef_t;

  // Front end to divider: magnitudes, the quotient sign and the temperature riding along.
  typedef struct packed {
    logic        [75:0] dividend;
    logic        [41:0] divisor;
    logic               neg;
    logic               zero;
    logic signed [23:0] temp;
  } front_out_t;

  typedef struct packed {
    logic        [41:0] rem;
    logic        [39:0] low;
    logic        [39:0] quo;
    logic        [41:0] divisor;
    logic               neg;
    logic               sat;
    logic               zero;
    logic signed [23:0] temp;
  } div_stage_t;

  typedef struct packed {
    logic signed [40:0] quot;
    logic               zero;
    logic signed [23:0] temp;
  } div_out_t;

endpackage

/* sv/bpc_front.sv */
// Temperature compensation and the pressure numerator and divisor, eleven stages.
module bpc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  bpc_pkg::in_item_t     item_i,
  input  bpc_pkg::coef_t        coef_i,
  output logic                  valid_o,
  output bpc_pkg::front_out_t   data_o
);

  localparam int unsigned N = bpc_pkg::FRONT_STAGES;

  logic [N-1:0] v_q;

  // Stage 1
  logic        [19:0] p1_rawp_q;
  logic signed [17:0] ta_d, ta_q;
  logic signed [16:0] tb_d, tb_q;
  // Stage 2
  logic        [19:0] p2_rawp_q;
  logic signed [33:0] prod_a, prod_bb;
  logic signed [22:0] a1_d, a1_q, p3_a1_q;
  logic        [20:0] bb_d, bb_q;
  // Stage 3
  logic        [19:0] p3_rawp_q;
  logic signed [37:0] prod_b;
  logic signed [23:0] b1_d, b1_q;
  // Stage 4
  logic        [19:0] p4_rawp_q;
  logic signed [24:0] fine_d, fine_q;
  // Stage 5
  logic        [19:0] p5_rawp_q;
  logic signed [27:0] fine5;
  logic signed [23:0] temp_d, temp_q;
  logic signed [25:0] pa_d, pa_q;
  // Stage 6
  logic        [19:0] p6_rawp_q;
  logic signed [23:0] p6_temp_q;
  logic signed [51:0] prod_aa;
  logic        [50:0] aa_d, aa_q;
  logic signed [41:0] ap5_d, ap5_q, ap2_d, ap2_q;
  // Stage 7
  logic        [19:0] p7_rawp_q;
  logic signed [23:0] p7_temp_q;
  logic signed [67:0] prod_p6, prod_p3;
  logic signed [63:0] aap6_q, aap3_q;
  logic signed [41:0] p7_ap5_q, p7_ap2_q;
  // Stage 8
  logic        [19:0] p8_rawp_q;
  logic signed [23:0] p8_temp_q;
  logic signed [63:0] bsum_d, bsum_q;
  logic signed [57:0] x_d, x_q;
  // Stage 9
  logic signed [23:0] p9_temp_q;
  logic signed [74:0] prod_d;
  logic signed [41:0] d_d, d_q;
  logic        [20:0] pdiff;
  logic        [63:0] num_d, num_q;
  // Stage 10
  logic signed [23:0] p10_temp_q;
  logic        [63:0] am_d, am_q;
  logic        [41:0] dm_d, dm_q;
  logic               neg_q, zero_q;
  // Stage 11
  bpc_pkg::front_out_t out_d, out_q;

  always_comb begin
    ta_d    = $signed({1'b0, item_i.raw_temperature[19:3]}) - $signed({1'b0, coef_i.t1, 1'b0});
    tb_d    = $signed({1'b0, item_i.raw_temperature[19:4]}) - $signed({1'b0, coef_i.t1});
    prod_a  = ta_q * coef_i.t2;
    a1_d    = prod_a[33:11];
    prod_bb = tb_q * tb_q;
    bb_d    = prod_bb[32:12];
    prod_b  = $signed({1'b0, bb_q}) * coef_i.t3;
    b1_d    = prod_b[37:14];
    fine_d  = 25'(p3_a1_q) + 25'(b1_q);
    // The temperature span of the formula always fits in 24 bits.
    fine5   = (28'(fine_q) <<< 2) + 28'(fine_q) + 28'sd128;
    temp_d  = 24'($signed(fine5[27:8]));
    pa_d    = 26'(fine_q) - 26'sd128000;
    prod_aa = pa_q * pa_q;
    aa_d    = prod_aa[50:0];
    ap5_d   = pa_q * coef_i.p5;
    ap2_d   = pa_q * coef_i.p2;
    prod_p6 = $signed({1'b0, aa_q}) * coef_i.p6;
    prod_p3 = $signed({1'b0, aa_q}) * coef_i.p3;
    // The second-order sums wrap: bsum modulo 2^64 and x modulo 2^58.
    bsum_d  = aap6_q + (64'(p7_ap5_q) <<< 17) + (64'(coef_i.p4) <<< 35);
    x_d     = 58'($signed(aap3_q[63:8])) + (58'(p7_ap2_q) <<< 12) + 58'sh8000_0000_0000;
    prod_d  = x_q * $signed({1'b0, coef_i.p1});
    d_d     = prod_d[74:33];
    pdiff   = 21'h10_0000 - {1'b0, p8_rawp_q};
    num_d   = {12'd0, pdiff, 31'd0} - $unsigned(bsum_q);
    am_d    = num_q[63] ? (64'd0 - num_q) : num_q;
    dm_d    = d_q[41] ? (42'd0 - $unsigned(d_q)) : $unsigned(d_q);
    out_d.dividend = 76'(am_q) * 76'd3125;
    out_d.divisor  = dm_q;
    out_d.neg      = neg_q;
    out_d.zero     = zero_q;
    out_d.temp     = p10_temp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_rawp_q  <= item_i.raw_pressure;
      ta_q       <= ta_d;
      tb_q       <= tb_d;
      p2_rawp_q  <= p1_rawp_q;
      a1_q       <= a1_d;
      bb_q       <= bb_d;
      p3_rawp_q  <= p2_rawp_q;
      p3_a1_q    <= a1_q;
      b1_q       <= b1_d;
      p4_rawp_q  <= p3_rawp_q;
      fine_q     <= fine_d;
      p5_rawp_q  <= p4_rawp_q;
      temp_q     <= temp_d;
      pa_q       <= pa_d;
      p6_rawp_q  <= p5_rawp_q;
      p6_temp_q  <= temp_q;
      aa_q       <= aa_d;
      ap5_q      <= ap5_d;
      ap2_q      <= ap2_d;
      p7_rawp_q  <= p6_rawp_q;
      p7_temp_q  <= p6_temp_q;
      aap6_q     <= prod_p6[63:0];
      aap3_q     <= prod_p3[63:0];
      p7_ap5_q   <= ap5_q;
      p7_ap2_q   <= ap2_q;
      p8_rawp_q  <= p7_rawp_q;
      p8_temp_q  <= p7_temp_q;
      bsum_q     <= bsum_d;
      x_q        <= x_d;
      p9_temp_q  <= p8_temp_q;
      d_q        <= d_d;
      num_q      <= num_d;
      p10_temp_q <= p9_temp_q;
      am_q       <= am_d;
      dm_q       <= dm_d;
      neg_q      <= num_q[63] ^ d_q[41];
      zero_q     <= (d_q == '0);
      out_q      <= out_d;
    end
  end

  assign valid_o = v_q[N-1];
  assign data_o  = out_q;

endmodule

/* sv/bpc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with saturation.
module bpc_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  bpc_pkg::front_out_t   data_i,
  output logic                  valid_o,
  output bpc_pkg::div_out_t     data_o
);

  localparam int unsigned STEPS = bpc_pkg::QUOT_BITS;

  function automatic bpc_pkg::div_stage_t div_step(input bpc_pkg::div_stage_t s);
    logic [42:0]         trial;
    logic                ge;
    bpc_pkg::div_stage_t r;
    trial   = {s.rem, s.low[39]};
    ge      = trial >= {1'b0, s.divisor};
    r       = s;
    r.rem   = ge ? 42'(trial - {1'b0, s.divisor}) : trial[41:0];
    r.low   = {s.low[38:0], 1'b0};
    r.quo   = {s.quo[38:0], ge};
    return r;
  endfunction

  bpc_pkg::div_stage_t st_d [STEPS+1];
  bpc_pkg::div_stage_t st_q [STEPS+1];
  logic [STEPS+1:0]    v_q;
  logic [39:0]         qmag;
  bpc_pkg::div_out_t   out_d, out_q;

  // A quotient of 2^40 or more shows in the top bits alone; the remainder
  // then starts below the divisor, so 40 steps finish the rest.
  always_comb begin
    st_d[0].rem     = 42'(data_i.dividend[75:40]);
    st_d[0].low     = data_i.dividend[39:0];
    st_d[0].quo     = '0;
    st_d[0].divisor = data_i.divisor;
    st_d[0].neg     = data_i.neg;
    st_d[0].sat     = {6'd0, data_i.dividend[75:40]} >= data_i.divisor;
    st_d[0].zero    = data_i.zero;
    st_d[0].temp    = data_i.temp;
  end

  for (genvar i = 1; i <= STEPS; i++) begin : g_step
    assign st_d[i] = div_step(st_q[i-1]);
  end

  always_comb begin
    qmag       = st_q[STEPS].sat ? '1 : st_q[STEPS].quo;
    out_d.quot = st_q[STEPS].neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    out_d.zero = st_q[STEPS].zero;
    out_d.temp = st_q[STEPS].temp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STEPS:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= STEPS; k++) begin
        st_q[k] <= st_d[k];
      end
      out_q <= out_d;
    end
  end

  assign valid_o = v_q[STEPS+1];
  assign data_o  = out_q;

endmodule

/* sv/bpc_back.sv */
// Second-order pressure correction, offset, saturation and the output register.
module bpc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  bpc_pkg::div_out_t    data_i,
  input  bpc_pkg::coef_t       coef_i,
  output logic                 valid_o,
  output bpc_pkg::out_item_t   item_o
);

  localparam int unsigned N = bpc_pkg::BACK_STAGES;

  logic [N-1:0] v_q;

  logic signed [40:0] p1_q, p2_q, p3_q;
  logic signed [27:0] c1_q;
  logic signed [56:0] c2raw_d, c2raw_q;
  logic signed [55:0] prod_x;
  logic        [54:0] x_q;
  logic signed [37:0] c2_q, p3_c2_q;
  logic signed [71:0] prod_c1;
  logic signed [46:0] c1t_q;
  logic signed [47:0] s_d, s_q;
  logic signed [41:0] r;
  logic               z1_q, z2_q, z3_q, z4_q;
  logic signed [23:0] t1_q, t2_q, t3_q, t4_q;
  bpc_pkg::out_item_t out_d, out_q;

  always_comb begin
    c2raw_d = data_i.quot * coef_i.p8;
    prod_x  = c1_q * c1_q;
    prod_c1 = $signed({1'b0, x_q}) * coef_i.p9;
    s_d     = 48'(p3_q) + 48'(c1t_q) + 48'(p3_c2_q);
    r       = 42'($signed(s_q[47:8])) + (42'(coef_i.p7) <<< 4);
    out_d.temp_centi = t4_q;
    out_d.pressure_ok = !z4_q;
    if (z4_q || r[41]) begin
      out_d.pressure_q24_8 = '0;
    end else if (r[40:32] != '0) begin
      out_d.pressure_q24_8 = '1;
    end else begin
      out_d.pressure_q24_8 = r[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q    <= data_i.quot;
      c1_q    <= data_i.quot[40:13];
      c2raw_q <= c2raw_d;
      z1_q    <= data_i.zero;
      t1_q    <= data_i.temp;
      p2_q    <= p1_q;
      x_q     <= prod_x[54:0];
      c2_q    <= c2raw_q[56:19];
      z2_q    <= z1_q;
      t2_q    <= t1_q;
      p3_q    <= p2_q;
      c1t_q   <= prod_c1[71:25];
      p3_c2_q <= c2_q;
      z3_q    <= z2_q;
      t3_q    <= t2_q;
      s_q     <= s_d;
      z4_q    <= z3_q;
      t4_q    <= t3_q;
      out_q   <= out_d;
    end
  end

  assign valid_o = v_q[N-1];
  assign item_o  = out_q;

endmodule

/* sv/baro_pressure_temp_compensation_top.sv */
// Top level of the barometric temperature and pressure compensation pipeline.
//
// Input channel: in_valid_i with in_i (raw pressure and raw temperature); the
// item is taken on a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o with out_o; the receiver holds out_stall_i high
// to keep an item waiting, and the item stays unchanged until taken.
// Calibration words are written through cfg_valid_i, cfg_index_i and
// cfg_data_i; cfg_ready_o is always high. Write them only while no item is
// in flight.
// Throughput is one item per cycle while no stalled item waits at the output.
// The stages are 11 of temperature and coefficient arithmetic, 42 of the
// bit-per-stage divider and 5 of the final correction, the last the output register.
// All stages advance together, so a stalled result stops the whole pipeline
// and in_stall_o follows out_stall_i while an item waits at the output.
// Reset clears every valid bit and all calibration words to zero.
module baro_pressure_temp_compensation_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bpc_pkg::in_item_t                  in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bpc_pkg::out_item_t                 out_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [47:0] temp_coef_q;
  logic [63:0] press_lo_q;
  logic [63:0] press_hi_q;
  logic [15:0] press_p9_q;

  bpc_pkg::coef_t      coef;
  bpc_pkg::front_out_t front_data;
  bpc_pkg::div_out_t   div_data;
  logic                front_valid, div_valid, en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coef_q <= '0;
      press_lo_q  <= '0;
      press_hi_q  <= '0;
      press_p9_q  <= '0;
    end else if (cfg_valid_i) begin
      case (bpc_pkg::cfg_idx_e'(cfg_index_i))
        bpc_pkg::CFG_TEMP:     temp_coef_q <= cfg_data_i[47:0];
        bpc_pkg::CFG_PRESS_LO: press_lo_q  <= cfg_data_i;
        bpc_pkg::CFG_PRESS_HI: press_hi_q  <= cfg_data_i;
        bpc_pkg::CFG_PRESS_P9: press_p9_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.t1 = temp_coef_q[15:0];
    coef.t2 = $signed(temp_coef_q[31:16]);
    coef.t3 = $signed(temp_coef_q[47:32]);
    coef.p1 = press_lo_q[15:0];
    coef.p2 = $signed(press_lo_q[31:16]);
    coef.p3 = $signed(press_lo_q[47:32]);
    coef.p4 = $signed(press_lo_q[63:48]);
    coef.p5 = $signed(press_hi_q[15:0]);
    coef.p6 = $signed(press_hi_q[31:16]);
    coef.p7 = $signed(press_hi_q[47:32]);
    coef.p8 = $signed(press_hi_q[63:48]);
    coef.p9 = $signed(press_p9_q);
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  bpc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_i),
    .coef_i  (coef),
    .valid_o (front_valid),
    .data_o  (front_data)
  );

  bpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .data_i  (front_data),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  bpc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .data_i  (div_data),
    .coef_i  (coef),
    .valid_o (out_valid_o),
    .item_o  (out_o)
  );

endmodule
